// ===== hdl/scr_pkg.sv =====
// ----------------------------------------------------------------------------
// scr_pkg: shared definitions for the scissor rectangle stack
// Command and status codes, register indexes and default sizes.
// ----------------------------------------------------------------------------
package scr_pkg;

    // Default sizes, handed to the top-level parameters.
    localparam int DEF_STACK_DEPTH = 256;
    localparam int DEF_COORD_BITS  = 16;

    // Fixed field widths.
    localparam int VIEW_BITS   = 15;
    localparam int DEPTH_BITS  = 9;
    localparam int STATUS_BITS = 2;
    localparam int CFG_IDX_BITS = 1;

    // Command kinds.
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_NEG_SIZE  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_VIEW_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VIEW_HEIGHT = 1'b1;

endpackage

// ===== hdl/scissor_rect_stack.sv =====
// A command passes through the input register and then the result register,
// which raises the result strobe and holds the result.
// Throughput: one command per cycle; busy stays low, since the top entry is
// held in registers and the entry below it is in a bypass register or the RAM.
// Reset clears the stack and the view registers; results cannot be stalled.
// ----------------------------------------------------------------------------
// scissor_rect_stack: clipping rectangle stack with intersection
// Push stores the rectangle (intersected with the top, if any), pop removes
// the top; each request gives the effective clip rectangle, status and depth.
// ----------------------------------------------------------------------------
module scissor_rect_stack #(
    parameter int STACK_DEPTH = scr_pkg::DEF_STACK_DEPTH,
    parameter int COORD_BITS  = scr_pkg::DEF_COORD_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Command channel
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_kind,
    input  logic signed [COORD_BITS-1:0]         i_rect_x,
    input  logic signed [COORD_BITS-1:0]         i_rect_y,
    input  logic signed [COORD_BITS-1:0]         i_rect_w,
    input  logic signed [COORD_BITS-1:0]         i_rect_h,
    // Result channel
    output logic                                 o_valid,
    output logic                                 o_clip_enable,
    output logic signed [COORD_BITS-1:0]         o_clip_x,
    output logic signed [COORD_BITS-1:0]         o_clip_y,
    output logic signed [COORD_BITS-1:0]         o_clip_w,
    output logic signed [COORD_BITS-1:0]         o_clip_h,
    output logic [scr_pkg::STATUS_BITS-1:0]      o_status,
    output logic [scr_pkg::DEPTH_BITS-1:0]       o_depth,
    // Configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [scr_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [scr_pkg::VIEW_BITS-1:0]        i_cfg_data
);

    import scr_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int RW = 4 * COORD_BITS;

    // Input register.
    logic                         r_req_valid;
    logic                         r_kind;
    logic signed [COORD_BITS-1:0] r_x, r_y, r_w, r_h;

    // Stack state: count, cached top, bypass copy of the entry below the top.
    logic [CW-1:0]   r_count, n_count;
    logic [RW-1:0]   r_top, n_top;
    logic [RW-1:0]   r_byp;
    logic            r_use_byp;
    logic [RW-1:0]   ram_rdata, below;

    // View size registers.
    logic [VIEW_BITS-1:0] r_view_w, r_view_h;

    // Result register.
    logic                         r_out_valid;
    logic                         r_out_en;
    logic [RW-1:0]                r_out_rect;
    logic [STATUS_BITS-1:0]       r_out_status, n_status;
    logic [DEPTH_BITS-1:0]        r_out_depth;

    logic            empty, full, is_push, is_pop, push_ok, pop_ok, neg_size;
    logic [RW-1:0]   in_rect, isect_rect, view_rect, n_out_rect;
    logic [CW-1:0]   cnt_m1, cnt_m2, cnt_m3;
    logic [AW-1:0]   ram_raddr, ram_waddr;
    logic signed [COORD_BITS-1:0] is_x, is_y, is_w, is_h;
    logic [VIEW_BITS+COORD_BITS-1:0] view_w_ext, view_h_ext;
    logic [DEPTH_BITS+CW-1:0]        depth_ext;

    // Every command is taken as it comes; configuration is always accepted.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Capture the request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else begin
            r_req_valid <= start && !busy;
        end
        r_kind <= i_kind;
        r_x    <= i_rect_x;
        r_y    <= i_rect_y;
        r_w    <= i_rect_w;
        r_h    <= i_rect_h;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_w <= '0;
            r_view_h <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_VIEW_WIDTH:  r_view_w <= i_cfg_data;
                CFG_VIEW_HEIGHT: r_view_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Command decode against the current stack state.
    assign empty    = (r_count == '0);
    assign full     = (r_count == CW'(STACK_DEPTH));
    assign is_push  = r_req_valid && (r_kind == KIND_PUSH);
    assign is_pop   = r_req_valid && (r_kind == KIND_POP);
    assign push_ok  = is_push && !full;
    assign pop_ok   = is_pop && !empty;
    assign neg_size = r_w[COORD_BITS-1] || r_h[COORD_BITS-1];

    assign cnt_m1 = r_count - CW'(1);
    assign cnt_m2 = r_count - CW'(2);
    assign cnt_m3 = r_count - CW'(3);

    // Intersection of the pushed rectangle with the top.
    assign in_rect = {r_x, r_y, r_w, r_h};

    scr_isect #(
        .COORD_BITS (COORD_BITS)
    ) u_isect (
        .i_top_x (r_top[4*COORD_BITS-1:3*COORD_BITS]),
        .i_top_y (r_top[3*COORD_BITS-1:2*COORD_BITS]),
        .i_top_w (r_top[2*COORD_BITS-1:COORD_BITS]),
        .i_top_h (r_top[COORD_BITS-1:0]),
        .i_x     (r_x),
        .i_y     (r_y),
        .i_w     (r_w),
        .i_h     (r_h),
        .o_x     (is_x),
        .o_y     (is_y),
        .o_w     (is_w),
        .o_h     (is_h)
    );

    assign isect_rect = {is_x, is_y, is_w, is_h};

    // Entries below the top live in the RAM. A push spills the old top and holds
    // it as the bypass copy; else the read port reads the entry below the top.
    assign below     = r_use_byp ? r_byp : ram_rdata;
    assign ram_waddr = cnt_m1[AW-1:0];
    assign ram_raddr = pop_ok ? cnt_m3[AW-1:0] : cnt_m2[AW-1:0];

    scr_ram #(
        .WIDTH (RW),
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (push_ok && !empty),
        .i_waddr (ram_waddr),
        .i_wdata (r_top),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next stack state and status.
    always_comb begin
        n_count  = r_count;
        n_top    = r_top;
        n_status = ST_OK;
        if (is_push) begin
            if (full) begin
                n_status = ST_OVERFLOW;
            end else begin
                n_count  = r_count + CW'(1);
                n_top    = empty ? in_rect : isect_rect;
                n_status = neg_size ? ST_NEG_SIZE : ST_OK;
            end
        end else if (is_pop) begin
            if (empty) begin
                n_status = ST_UNDERFLOW;
            end else begin
                n_count = cnt_m1;
                n_top   = below;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_use_byp <= 1'b0;
        end else begin
            r_count <= n_count;
            if (push_ok) begin
                r_use_byp <= 1'b1;
            end else if (pop_ok) begin
                r_use_byp <= 1'b0;
            end
        end
        r_top <= n_top;
        if (push_ok) begin
            r_byp <= r_top;
        end
    end

    // Effective rectangle: the new top, or the whole view when empty.
    assign view_w_ext = {{COORD_BITS{1'b0}}, r_view_w};
    assign view_h_ext = {{COORD_BITS{1'b0}}, r_view_h};
    assign view_rect  = {{(2*COORD_BITS){1'b0}},
                         view_w_ext[COORD_BITS-1:0], view_h_ext[COORD_BITS-1:0]};
    assign n_out_rect = (n_count != '0) ? n_top : view_rect;
    assign depth_ext  = {{DEPTH_BITS{1'b0}}, n_count};

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_req_valid;
        end
        r_out_en     <= (n_count != '0);
        r_out_rect   <= n_out_rect;
        r_out_status <= n_status;
        r_out_depth  <= depth_ext[DEPTH_BITS-1:0];
    end

    assign o_valid       = r_out_valid;
    assign o_clip_enable = r_out_en;
    assign o_clip_x      = r_out_rect[4*COORD_BITS-1:3*COORD_BITS];
    assign o_clip_y      = r_out_rect[3*COORD_BITS-1:2*COORD_BITS];
    assign o_clip_w      = r_out_rect[2*COORD_BITS-1:COORD_BITS];
    assign o_clip_h      = r_out_rect[COORD_BITS-1:0];
    assign o_status      = r_out_status;
    assign o_depth       = r_out_depth;

endmodule

// ===== hdl/scr_ram.sv =====
// ----------------------------------------------------------------------------
// scr_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module scr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/scr_isect.sv =====
// ----------------------------------------------------------------------------
// scr_isect: rectangle intersection
// Intersects a new rectangle with the current top; edge sums are one bit
// wider than the coordinates and the resulting size is clamped at zero.
// ----------------------------------------------------------------------------
module scr_isect #(
    parameter int COORD_BITS = 16
) (
    input  logic signed [COORD_BITS-1:0] i_top_x,
    input  logic signed [COORD_BITS-1:0] i_top_y,
    input  logic signed [COORD_BITS-1:0] i_top_w,
    input  logic signed [COORD_BITS-1:0] i_top_h,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  logic signed [COORD_BITS-1:0] i_w,
    input  logic signed [COORD_BITS-1:0] i_h,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y,
    output logic signed [COORD_BITS-1:0] o_w,
    output logic signed [COORD_BITS-1:0] o_h
);

    logic signed [COORD_BITS:0]   top_right, top_bottom, new_right, new_bottom;
    logic signed [COORD_BITS:0]   right, bottom;
    logic signed [COORD_BITS+1:0] span_w, span_h;

    // Right and bottom ends of both rectangles, without wrap.
    assign top_right  = (COORD_BITS+1)'(i_top_x) + (COORD_BITS+1)'(i_top_w);
    assign top_bottom = (COORD_BITS+1)'(i_top_y) + (COORD_BITS+1)'(i_top_h);
    assign new_right  = (COORD_BITS+1)'(i_x) + (COORD_BITS+1)'(i_w);
    assign new_bottom = (COORD_BITS+1)'(i_y) + (COORD_BITS+1)'(i_h);

    // Left and top edges are the larger of the two.
    assign o_x = (i_top_x > i_x) ? i_top_x : i_x;
    assign o_y = (i_top_y > i_y) ? i_top_y : i_y;

    // Smaller end minus the new edge, clamped at zero.
    assign right  = (top_right < new_right) ? top_right : new_right;
    assign bottom = (top_bottom < new_bottom) ? top_bottom : new_bottom;
    assign span_w = (COORD_BITS+2)'(right) - (COORD_BITS+2)'(o_x);
    assign span_h = (COORD_BITS+2)'(bottom) - (COORD_BITS+2)'(o_y);

    assign o_w = (span_w < 0) ? '0 : span_w[COORD_BITS-1:0];
    assign o_h = (span_h < 0) ? '0 : span_h[COORD_BITS-1:0];

endmodule
